// ----- sv/gdda_pkg.sv -----
`timescale 1ns / 1ps

package gdda_pkg;

  // Fixed-point formats and field widths
  localparam int FRAC_BITS  = 10;
  localparam int ANGLE_BITS = 12;
  localparam int MAP_BITS   = 6;
  localparam int CELL_BITS  = 8;
  localparam int ADDR_BITS  = 2 * MAP_BITS;
  localparam int MEM_DEPTH  = 1 << ADDR_BITS;
  localparam int POS_W      = 16;
  localparam int DIST_W     = 17;
  localparam int HIT_W      = 18;
  localparam int MAG_W      = 15;
  localparam int DELTA_W    = FRAC_BITS + 15;
  localparam int SIDE_W     = DELTA_W + 1;
  localparam int MULA_W     = 25;
  localparam int MULB_W     = 17;
  localparam int PROD_W     = MULA_W + MULB_W;
  localparam int MCELL_W    = MAP_BITS + 2;

  localparam logic [6:0]  MAP_DIM      = 7'd64;
  localparam logic [11:0] QUARTER_TURN = 12'd1024;
  localparam logic [DELTA_W-1:0] DELTA_MAX = DELTA_W'(1) << (FRAC_BITS + 14);
  localparam logic [FRAC_BITS:0] FRAC_ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;

  // Quarter-sine polynomial coefficients
  localparam logic [14:0] C_SIN_A = 15'd1160;
  localparam logic [14:0] C_SIN_B = 15'd10512;
  localparam logic [14:0] C_SIN_C = 15'd25736;

  // Register indexes and reset values
  localparam logic [1:0] REG_MAX_DIST   = 2'd0;
  localparam logic [1:0] REG_WALL_CODE  = 2'd1;
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd2;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd3;
  localparam logic [DIST_W-1:0]    RST_MAX_DIST  = 17'd20480;
  localparam logic [CELL_BITS-1:0] RST_WALL_CODE = 8'd1;
  localparam logic [6:0]           RST_MAP_DIM   = 7'd64;

  localparam logic [CELL_BITS-1:0] CODE_LIMIT = 8'd0;
  localparam logic [CELL_BITS-1:0] CODE_OOB   = 8'd1;
  localparam logic                 OP_WRITE   = 1'b0;
  localparam logic                 OP_CAST    = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_TRIG0, ST_TRIG1, ST_TRIG2, ST_TRIG3, ST_TRIG4,
    ST_DIV, ST_SIDE0, ST_SIDE1, ST_STEP, ST_CHECK, ST_HIT0, ST_HIT1, ST_HIT2
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_TRIG0, CMD_TRIG1, CMD_TRIG2, CMD_TRIG3,
    CMD_TRIG4, CMD_DIV, CMD_SIDE0, CMD_SIDE1, CMD_STEP, CMD_CHECK, CMD_HIT0,
    CMD_HIT1, CMD_OUT
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic axis;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic stop;
    logic out_free;
  } status_t;

endpackage

// ----- sv/grid_ray_caster_dda.sv -----
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid_i/in_ready_o  operation, write_x/y, write_value, pos_x/y, angle
// out      out_valid_o/out_ready_i distance, hit_x, hit_y, cell_value, side
// cfg      cfg_we_i               cfg_addr_i, cfg_wdata_i
//
// A map write is stored in the cycle it is taken. Per axis a cast runs a sine on
// the shared multiplier (TRIG0-TRIG4), the reciprocal divider and side states
// SIDE0/SIDE1. A step advances and reads the map in STEP, tests it in CHECK.
// After reset a clearing pass zeroes the map with in_ready_o low.
// A stalled result sits in the output register; the next item is taken meanwhile.
module grid_ray_caster_dda (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_addr_i,
  input  logic [gdda_pkg::DIST_W-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [gdda_pkg::MAP_BITS-1:0]   write_x_i,
  input  logic [gdda_pkg::MAP_BITS-1:0]   write_y_i,
  input  logic [gdda_pkg::CELL_BITS-1:0]  write_value_i,
  input  logic [gdda_pkg::POS_W-1:0]      pos_x_i,
  input  logic [gdda_pkg::POS_W-1:0]      pos_y_i,
  input  logic [gdda_pkg::ANGLE_BITS-1:0] angle_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [gdda_pkg::DIST_W-1:0]     distance_o,
  output logic signed [gdda_pkg::HIT_W-1:0] hit_x_o,
  output logic signed [gdda_pkg::HIT_W-1:0] hit_y_o,
  output logic [gdda_pkg::CELL_BITS-1:0]  cell_value_o,
  output logic                            side_o
);

  gdda_pkg::cmd_t    cmd;
  gdda_pkg::status_t status;

  gdda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_ready_o  (in_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gdda_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .operation_i   (operation_i),
    .write_x_i     (write_x_i),
    .write_y_i     (write_y_i),
    .write_value_i (write_value_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .angle_i       (angle_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .distance_o    (distance_o),
    .hit_x_o       (hit_x_o),
    .hit_y_o       (hit_y_o),
    .cell_value_o  (cell_value_o),
    .side_o        (side_o)
  );

endmodule

// ----- sv/gdda_div.sv -----
`timescale 1ns / 1ps

// Restoring divider: 2^(FRAC_BITS+14) / divisor, one quotient bit per cycle
module gdda_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gdda_pkg::MAG_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [gdda_pkg::DELTA_W-1:0]  quotient_o
);

  localparam int CNT_W = $clog2(gdda_pkg::DELTA_W);
  localparam logic [CNT_W-1:0] TOP_BIT = CNT_W'(gdda_pkg::DELTA_W - 1);

  logic                         busy_q;
  logic                         done_q;
  logic [CNT_W-1:0]             cnt_q;
  logic [gdda_pkg::MAG_W:0]     rem_q, rem_sh;
  logic [gdda_pkg::MAG_W-1:0]   div_q;
  logic [gdda_pkg::DELTA_W-1:0] quo_q;
  logic                         fit;

  // Shift in the next dividend bit; only the top bit is set
  assign rem_sh = {rem_q[gdda_pkg::MAG_W-1:0], cnt_q == TOP_BIT};
  assign fit    = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= TOP_BIT;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fit ? rem_sh - {1'b0, div_q} : rem_sh;
      quo_q <= {quo_q[gdda_pkg::DELTA_W-2:0], fit};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- sv/gdda_dp.sv -----
`timescale 1ns / 1ps

module gdda_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  gdda_pkg::cmd_t                  cmd_i,
  output gdda_pkg::status_t               status_o,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_addr_i,
  input  logic [gdda_pkg::DIST_W-1:0]     cfg_wdata_i,
  input  logic                            operation_i,
  input  logic [gdda_pkg::MAP_BITS-1:0]   write_x_i,
  input  logic [gdda_pkg::MAP_BITS-1:0]   write_y_i,
  input  logic [gdda_pkg::CELL_BITS-1:0]  write_value_i,
  input  logic [gdda_pkg::POS_W-1:0]      pos_x_i,
  input  logic [gdda_pkg::POS_W-1:0]      pos_y_i,
  input  logic [gdda_pkg::ANGLE_BITS-1:0] angle_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [gdda_pkg::DIST_W-1:0]     distance_o,
  output logic signed [gdda_pkg::HIT_W-1:0] hit_x_o,
  output logic signed [gdda_pkg::HIT_W-1:0] hit_y_o,
  output logic [gdda_pkg::CELL_BITS-1:0]  cell_value_o,
  output logic                            side_o
);

  localparam int FB = gdda_pkg::FRAC_BITS;
  localparam logic signed [gdda_pkg::HIT_W:0] HIT_MAX = 19'sd131071;
  localparam logic signed [gdda_pkg::HIT_W:0] HIT_MIN = -19'sd131072;

  // Add or subtract the scaled term and saturate to the hit range
  function automatic logic [gdda_pkg::HIT_W-1:0] hit_sat(
    input logic [gdda_pkg::POS_W-1:0]  pos,
    input logic                        neg,
    input logic [gdda_pkg::DIST_W-1:0] t
  );
    logic signed [gdda_pkg::HIT_W:0] v;
    v = neg ? $signed({3'b000, pos}) - $signed({2'b00, t})
            : $signed({3'b000, pos}) + $signed({2'b00, t});
    if (v > HIT_MAX) v = HIT_MAX;
    if (v < HIT_MIN) v = HIT_MIN;
    return v[gdda_pkg::HIT_W-1:0];
  endfunction

  // Configuration
  logic [gdda_pkg::DIST_W-1:0]    max_dist_q;
  logic [gdda_pkg::CELL_BITS-1:0] wall_code_q;
  logic [6:0]                     map_w_q, map_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q  <= gdda_pkg::RST_MAX_DIST;
      wall_code_q <= gdda_pkg::RST_WALL_CODE;
      map_w_q     <= gdda_pkg::RST_MAP_DIM;
      map_h_q     <= gdda_pkg::RST_MAP_DIM;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        gdda_pkg::REG_MAX_DIST:   max_dist_q  <= cfg_wdata_i;
        gdda_pkg::REG_WALL_CODE:  wall_code_q <= cfg_wdata_i[gdda_pkg::CELL_BITS-1:0];
        gdda_pkg::REG_MAP_WIDTH:  map_w_q     <= cfg_wdata_i[6:0];
        gdda_pkg::REG_MAP_HEIGHT: map_h_q     <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // Map store with clearing sweep
  logic [gdda_pkg::CELL_BITS-1:0] mem_q [gdda_pkg::MEM_DEPTH];
  logic [gdda_pkg::CELL_BITS-1:0] rdata_q;
  logic [gdda_pkg::ADDR_BITS-1:0] clr_q, waddr, raddr;
  logic [gdda_pkg::CELL_BITS-1:0] wdata;
  logic                           we, is_clear;

  assign is_clear = cmd_i.op == gdda_pkg::CMD_CLEAR;
  assign we    = is_clear || (cmd_i.op == gdda_pkg::CMD_LOAD && operation_i == gdda_pkg::OP_WRITE);
  assign waddr = is_clear ? clr_q : {write_y_i, write_x_i};
  assign wdata = is_clear ? '0 : write_value_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (is_clear) clr_q <= clr_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  // Item registers
  logic [gdda_pkg::POS_W-1:0]      px_q, py_q;
  logic [gdda_pkg::ANGLE_BITS-1:0] ang_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == gdda_pkg::CMD_LOAD) begin
      px_q  <= pos_x_i;
      py_q  <= pos_y_i;
      ang_q <= angle_i;
    end
  end

  // Quarter-sine argument for the current axis
  logic [gdda_pkg::ANGLE_BITS-1:0] ang_eff;
  logic [1:0]  quad, quad_q;
  logic [10:0] qq;
  logic [14:0] z_new, z_q, z2_q, p14;

  assign ang_eff = cmd_i.axis ? ang_q : ang_q + gdda_pkg::QUARTER_TURN;
  assign quad    = ang_eff[11:10];
  assign qq      = quad[0] ? 11'd1024 - {1'b0, ang_eff[9:0]} : {1'b0, ang_eff[9:0]};
  assign z_new   = {qq, 4'b0000};

  // Shared multiplier
  logic [gdda_pkg::MULA_W-1:0] mul_a;
  logic [gdda_pkg::MULB_W-1:0] mul_b;
  logic [gdda_pkg::PROD_W-1:0] prod_q;
  logic                        mul_en;

  logic [gdda_pkg::MAG_W-1:0]   mag_q   [2];
  logic                         neg_q   [2];
  logic [gdda_pkg::DELTA_W-1:0] delta_q [2];
  logic [gdda_pkg::SIDE_W-1:0]  side_q  [2];
  logic [gdda_pkg::DIST_W-1:0]  dist_q;
  logic [FB-1:0]                frac;
  logic [FB:0]                  fterm;

  assign p14   = prod_q[28:14];
  assign frac  = cmd_i.axis ? py_q[FB-1:0] : px_q[FB-1:0];
  assign fterm = neg_q[cmd_i.axis] ? {1'b0, frac} : gdda_pkg::FRAC_ONE - {1'b0, frac};

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd_i.op)
      gdda_pkg::CMD_TRIG0: begin
        mul_a = gdda_pkg::MULA_W'(z_new);
        mul_b = gdda_pkg::MULB_W'(z_new);
      end
      gdda_pkg::CMD_TRIG1: begin
        mul_a = gdda_pkg::MULA_W'(p14);
        mul_b = gdda_pkg::MULB_W'(gdda_pkg::C_SIN_A);
      end
      gdda_pkg::CMD_TRIG2: begin
        mul_a = gdda_pkg::MULA_W'(z2_q);
        mul_b = gdda_pkg::MULB_W'(gdda_pkg::C_SIN_B - p14);
      end
      gdda_pkg::CMD_TRIG3: begin
        mul_a = gdda_pkg::MULA_W'(z_q);
        mul_b = gdda_pkg::MULB_W'(gdda_pkg::C_SIN_C - p14);
      end
      gdda_pkg::CMD_SIDE0: begin
        mul_a = delta_q[cmd_i.axis];
        mul_b = gdda_pkg::MULB_W'(fterm);
      end
      gdda_pkg::CMD_HIT0: begin
        mul_a = gdda_pkg::MULA_W'(dist_q);
        mul_b = gdda_pkg::MULB_W'(mag_q[0]);
      end
      gdda_pkg::CMD_HIT1: begin
        mul_a = gdda_pkg::MULA_W'(dist_q);
        mul_b = gdda_pkg::MULB_W'(mag_q[1]);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_a * mul_b;
    if (cmd_i.op == gdda_pkg::CMD_TRIG0) begin
      z_q    <= z_new;
      quad_q <= quad;
    end
    if (cmd_i.op == gdda_pkg::CMD_TRIG1) z2_q <= p14;
  end

  // Reciprocal unit
  logic                         div_start, div_done;
  logic [gdda_pkg::DELTA_W-1:0] quotient;

  assign div_start = cmd_i.op == gdda_pkg::CMD_TRIG4;

  gdda_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (p14),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // DDA walk state
  logic signed [gdda_pkg::MCELL_W-1:0] mx_q, my_q, mx_n, my_n;
  logic [gdda_pkg::SIDE_W-1:0]         prev_q;
  logic                                sd_q, step_x;
  logic [gdda_pkg::CELL_BITS-1:0]      code_q;

  assign step_x = side_q[0] < side_q[1];
  assign mx_n   = mx_q + (neg_q[0] ? -8'sd1 : 8'sd1);
  assign my_n   = my_q + (neg_q[1] ? -8'sd1 : 8'sd1);
  assign raddr  = step_x ? {my_q[5:0], mx_n[5:0]} : {my_n[5:0], mx_q[5:0]};

  // Stop test after each step
  logic [6:0]                  w_eff, h_eff;
  logic [gdda_pkg::DIST_W-1:0] lim;
  logic [gdda_pkg::SIDE_W-1:0] lim_w, raw;
  logic                        oob, wall, stop;
  logic [gdda_pkg::DIST_W-1:0] dist_c;
  logic [gdda_pkg::CELL_BITS-1:0] code_c;

  assign w_eff = (map_w_q > gdda_pkg::MAP_DIM) ? gdda_pkg::MAP_DIM : map_w_q;
  assign h_eff = (map_h_q > gdda_pkg::MAP_DIM) ? gdda_pkg::MAP_DIM : map_h_q;
  assign lim   = (max_dist_q == '0) ? gdda_pkg::DIST_W'(1) : max_dist_q;
  assign lim_w = gdda_pkg::SIDE_W'(lim);
  assign oob   = mx_q[gdda_pkg::MCELL_W-1] || (mx_q >= $signed({1'b0, w_eff}))
              || my_q[gdda_pkg::MCELL_W-1] || (my_q >= $signed({1'b0, h_eff}));
  assign wall  = rdata_q == wall_code_q;
  assign stop  = oob || wall || (prev_q > lim_w);
  assign raw   = (oob || wall) ? prev_q : lim_w;
  assign code_c = oob ? gdda_pkg::CODE_OOB : (wall ? rdata_q : gdda_pkg::CODE_LIMIT);
  assign dist_c = (raw == '0) ? gdda_pkg::DIST_W'(1)
                : (raw > lim_w) ? lim : raw[gdda_pkg::DIST_W-1:0];

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      gdda_pkg::CMD_TRIG4: begin
        mag_q[cmd_i.axis] <= p14;
        neg_q[cmd_i.axis] <= quad_q[1] && (p14 != '0);
      end
      gdda_pkg::CMD_DIV: begin
        if (div_done)
          delta_q[cmd_i.axis] <= (mag_q[cmd_i.axis] == '0) ? gdda_pkg::DELTA_MAX : quotient;
      end
      gdda_pkg::CMD_SIDE1: begin
        side_q[cmd_i.axis] <= prod_q[gdda_pkg::SIDE_W+FB-1:FB];
        if (cmd_i.axis) my_q <= gdda_pkg::MCELL_W'(py_q[gdda_pkg::POS_W-1:FB]);
        else            mx_q <= gdda_pkg::MCELL_W'(px_q[gdda_pkg::POS_W-1:FB]);
      end
      gdda_pkg::CMD_STEP: begin
        if (step_x) begin
          prev_q    <= side_q[0];
          side_q[0] <= side_q[0] + gdda_pkg::SIDE_W'(delta_q[0]);
          mx_q      <= mx_n;
          sd_q      <= 1'b0;
        end else begin
          prev_q    <= side_q[1];
          side_q[1] <= side_q[1] + gdda_pkg::SIDE_W'(delta_q[1]);
          my_q      <= my_n;
          sd_q      <= 1'b1;
        end
      end
      gdda_pkg::CMD_CHECK: begin
        dist_q <= dist_c;
        code_q <= code_c;
      end
      default: ;
    endcase
  end

  // Output register
  logic                              out_valid_q;
  logic signed [gdda_pkg::HIT_W-1:0] hx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == gdda_pkg::CMD_HIT1) hx_q <= hit_sat(px_q, neg_q[0], prod_q[30:14]);
    if (cmd_i.op == gdda_pkg::CMD_OUT) begin
      distance_o   <= dist_q;
      hit_x_o      <= hx_q;
      hit_y_o      <= hit_sat(py_q, neg_q[1], prod_q[30:14]);
      cell_value_o <= code_q;
      side_o       <= sd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.op == gdda_pkg::CMD_OUT) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  assign out_valid_o         = out_valid_q;
  assign status_o.clear_done = is_clear && (clr_q == '1);
  assign status_o.div_done   = div_done;
  assign status_o.stop       = stop;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// ----- sv/gdda_ctrl.sv -----
`timescale 1ns / 1ps

module gdda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              operation_i,
  output logic              in_ready_o,
  input  gdda_pkg::status_t status_i,
  output gdda_pkg::cmd_t    cmd_o
);

  gdda_pkg::state_e state_q, state_d;
  logic             axis_q, axis_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gdda_pkg::ST_CLEAR;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    axis_d     = axis_q;
    in_ready_o = 1'b0;
    cmd_o.op   = gdda_pkg::CMD_NONE;
    cmd_o.axis = axis_q;
    case (state_q)
      gdda_pkg::ST_CLEAR: begin
        cmd_o.op = gdda_pkg::CMD_CLEAR;
        if (status_i.clear_done) state_d = gdda_pkg::ST_IDLE;
      end
      gdda_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = gdda_pkg::CMD_LOAD;
          if (operation_i == gdda_pkg::OP_CAST) begin
            axis_d  = 1'b0;
            state_d = gdda_pkg::ST_TRIG0;
          end
        end
      end
      gdda_pkg::ST_TRIG0: begin
        cmd_o.op = gdda_pkg::CMD_TRIG0;
        state_d  = gdda_pkg::ST_TRIG1;
      end
      gdda_pkg::ST_TRIG1: begin
        cmd_o.op = gdda_pkg::CMD_TRIG1;
        state_d  = gdda_pkg::ST_TRIG2;
      end
      gdda_pkg::ST_TRIG2: begin
        cmd_o.op = gdda_pkg::CMD_TRIG2;
        state_d  = gdda_pkg::ST_TRIG3;
      end
      gdda_pkg::ST_TRIG3: begin
        cmd_o.op = gdda_pkg::CMD_TRIG3;
        state_d  = gdda_pkg::ST_TRIG4;
      end
      gdda_pkg::ST_TRIG4: begin
        cmd_o.op = gdda_pkg::CMD_TRIG4;
        state_d  = gdda_pkg::ST_DIV;
      end
      gdda_pkg::ST_DIV: begin
        cmd_o.op = gdda_pkg::CMD_DIV;
        if (status_i.div_done) state_d = gdda_pkg::ST_SIDE0;
      end
      gdda_pkg::ST_SIDE0: begin
        cmd_o.op = gdda_pkg::CMD_SIDE0;
        state_d  = gdda_pkg::ST_SIDE1;
      end
      gdda_pkg::ST_SIDE1: begin
        cmd_o.op = gdda_pkg::CMD_SIDE1;
        // Repeat the setup for the y axis, then walk
        if (axis_q) begin
          state_d = gdda_pkg::ST_STEP;
        end else begin
          axis_d  = 1'b1;
          state_d = gdda_pkg::ST_TRIG0;
        end
      end
      gdda_pkg::ST_STEP: begin
        cmd_o.op = gdda_pkg::CMD_STEP;
        state_d  = gdda_pkg::ST_CHECK;
      end
      gdda_pkg::ST_CHECK: begin
        cmd_o.op = gdda_pkg::CMD_CHECK;
        state_d  = status_i.stop ? gdda_pkg::ST_HIT0 : gdda_pkg::ST_STEP;
      end
      gdda_pkg::ST_HIT0: begin
        cmd_o.op = gdda_pkg::CMD_HIT0;
        state_d  = gdda_pkg::ST_HIT1;
      end
      gdda_pkg::ST_HIT1: begin
        cmd_o.op = gdda_pkg::CMD_HIT1;
        state_d  = gdda_pkg::ST_HIT2;
      end
      gdda_pkg::ST_HIT2: begin
        // Hold until the output register is free
        if (status_i.out_free) begin
          cmd_o.op = gdda_pkg::CMD_OUT;
          state_d  = gdda_pkg::ST_IDLE;
        end
      end
      default: state_d = gdda_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- sv/gdda_checker.sv -----
`timescale 1ns / 1ps

module gdda_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [1:0]                      cfg_addr_i,
  input logic [gdda_pkg::DIST_W-1:0]     cfg_wdata_i,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            operation_i,
  input logic [gdda_pkg::MAP_BITS-1:0]   write_x_i,
  input logic [gdda_pkg::MAP_BITS-1:0]   write_y_i,
  input logic [gdda_pkg::CELL_BITS-1:0]  write_value_i,
  input logic [gdda_pkg::POS_W-1:0]      pos_x_i,
  input logic [gdda_pkg::POS_W-1:0]      pos_y_i,
  input logic [gdda_pkg::ANGLE_BITS-1:0] angle_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [gdda_pkg::DIST_W-1:0]     distance_o,
  input logic signed [gdda_pkg::HIT_W-1:0] hit_x_o,
  input logic signed [gdda_pkg::HIT_W-1:0] hit_y_o,
  input logic [gdda_pkg::CELL_BITS-1:0]  cell_value_o,
  input logic                            side_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(distance_o) && $stable(hit_x_o)
      && $stable(hit_y_o) && $stable(cell_value_o) && $stable(side_o))
    else $error("result payload changed while stalled");

  // A cast keeps the block busy the next cycle
  a_cast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i |=> !in_ready_o)
    else $error("input taken right after a cast");

  // Distance is never below one LSB
  a_dist_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_o != '0)
    else $error("zero distance on a result");

endmodule

bind grid_ray_caster_dda gdda_checker u_gdda_checker (.*);
